// ===== design/gqi_pkg.sv =====
// Shared constants, codes and types of the gyro quaternion integrator.
// No dependencies; every other design file imports this package.
package gqi_pkg;

   localparam int QUAT_FRAC_BITS = 30;
   localparam int RATE_FRAC_BITS = 8;
   localparam int HALF_RAD_K     = 9825330;
   localparam int HALF_RAD_SHIFT = 50 - QUAT_FRAC_BITS + RATE_FRAC_BITS;
   localparam int RATE_W         = 20;
   localparam int QUAT_W         = 32;
   localparam int STEP_W         = 20;
   localparam int CSR_IDX_W      = 3;

   localparam logic signed [QUAT_W-1:0] Q_ONE = QUAT_W'(64'sd1 <<< QUAT_FRAC_BITS);
   localparam logic signed [QUAT_W-1:0] Q_MAX = {1'b0, {(QUAT_W-1){1'b1}}};
   localparam logic signed [QUAT_W-1:0] Q_MIN = {1'b1, {(QUAT_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_INTEGRATE = 2'd0,
      OP_IDENTITY  = 2'd1,
      OP_LAUNCH    = 2'd2,
      OP_NONE      = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BIAS_X   = 3'd0,
      CSR_BIAS_Y   = 3'd1,
      CSR_BIAS_Z   = 3'd2,
      CSR_LAUNCH_W = 3'd3,
      CSR_LAUNCH_X = 3'd4,
      CSR_LAUNCH_Y = 3'd5,
      CSR_LAUNCH_Z = 3'd6,
      CSR_UNUSED   = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      DP_IDLE    = 3'd0,
      DP_LOAD    = 3'd1,
      DP_MUL     = 3'd2,
      DP_UPDATE  = 3'd3,
      DP_SQ      = 3'd4,
      DP_SQRT    = 3'd5,
      DP_DIV     = 3'd6,
      DP_PUBLISH = 3'd7
   } dp_op_type;

   // Last step of each sequenced phase
   localparam logic [5:0] MUL_LAST  = 6'd41;
   localparam logic [5:0] SQ_LAST   = 6'd7;
   localparam logic [5:0] SQRT_LAST = 6'd32;
   localparam logic [5:0] DIV_LAST  = 6'd34;

   typedef struct packed {
      dp_op_type  op;
      logic [5:0] step;
      logic [1:0] part;
   } dp_cmd_type;

   typedef struct packed {
      logic zero_norm;
   } dp_status_type;

   typedef struct packed {
      logic [1:0] h;
      logic [1:0] q;
      logic [1:0] d;
      logic       neg;
   } term_type;

   // Terms of the quaternion product q * (0, h)
   function automatic term_type term_sel(input logic [3:0] t);
      term_type r;
      unique case (t)
         4'd0:    r = '{h: 2'd0, q: 2'd1, d: 2'd0, neg: 1'b1};
         4'd1:    r = '{h: 2'd1, q: 2'd2, d: 2'd0, neg: 1'b1};
         4'd2:    r = '{h: 2'd2, q: 2'd3, d: 2'd0, neg: 1'b1};
         4'd3:    r = '{h: 2'd0, q: 2'd0, d: 2'd1, neg: 1'b0};
         4'd4:    r = '{h: 2'd2, q: 2'd2, d: 2'd1, neg: 1'b0};
         4'd5:    r = '{h: 2'd1, q: 2'd3, d: 2'd1, neg: 1'b1};
         4'd6:    r = '{h: 2'd1, q: 2'd0, d: 2'd2, neg: 1'b0};
         4'd7:    r = '{h: 2'd2, q: 2'd1, d: 2'd2, neg: 1'b1};
         4'd8:    r = '{h: 2'd0, q: 2'd3, d: 2'd2, neg: 1'b0};
         4'd9:    r = '{h: 2'd2, q: 2'd0, d: 2'd3, neg: 1'b0};
         4'd10:   r = '{h: 2'd1, q: 2'd1, d: 2'd3, neg: 1'b0};
         4'd11:   r = '{h: 2'd0, q: 2'd2, d: 2'd3, neg: 1'b1};
         default: r = '{h: 2'd0, q: 2'd0, d: 2'd0, neg: 1'b0};
      endcase
      return r;
   endfunction

   function automatic logic signed [QUAT_W-1:0] sat_q(input logic signed [67:0] v);
      if (v > 68'(Q_MAX)) return Q_MAX;
      if (v < 68'(Q_MIN)) return Q_MIN;
      return QUAT_W'(v);
   endfunction

   function automatic logic signed [RATE_W-1:0] sat_rate(input logic signed [21:0] v);
      if (v > 22'sd524287) return {1'b0, {(RATE_W-1){1'b1}}};
      if (v < -22'sd524288) return {1'b1, {(RATE_W-1){1'b0}}};
      return RATE_W'(v);
   endfunction

endpackage

// ===== design/gqi_req_if.sv =====
// Input item channel of the gyro quaternion integrator.
// Depends on gqi_pkg for field widths.
interface gqi_req_if import gqi_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               opcode;
   logic signed [RATE_W-1:0] rate_sx;
   logic signed [RATE_W-1:0] rate_sy;
   logic signed [RATE_W-1:0] rate_sz;
   logic [STEP_W-1:0]        step_us;

   modport source (output valid, opcode, rate_sx, rate_sy, rate_sz, step_us, input ready);
   modport sink   (input valid, opcode, rate_sx, rate_sy, rate_sz, step_us, output ready);
endinterface

// ===== design/gqi_rsp_if.sv =====
// Result item channel of the gyro quaternion integrator.
// Depends on gqi_pkg for field widths.
interface gqi_rsp_if import gqi_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [QUAT_W-1:0] att_w;
   logic signed [QUAT_W-1:0] att_x;
   logic signed [QUAT_W-1:0] att_y;
   logic signed [QUAT_W-1:0] att_z;
   logic signed [RATE_W-1:0] body_rate_x;
   logic signed [RATE_W-1:0] body_rate_y;
   logic signed [RATE_W-1:0] body_rate_z;

   modport source (output valid, att_w, att_x, att_y, att_z,
                   body_rate_x, body_rate_y, body_rate_z, input ready);
   modport sink   (input valid, att_w, att_x, att_y, att_z,
                   body_rate_x, body_rate_y, body_rate_z, output ready);
endinterface

// ===== design/gqi_csr_if.sv =====
// Register write channel of the gyro quaternion integrator.
// Depends on gqi_pkg for the index width.
interface gqi_csr_if import gqi_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [31:0]          data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/gqi_datapath.sv =====
// Datapath: registers, shared multiplier, square root and divider steps.
// Driven by gqi_ctrl through dp_cmd_type; depends on gqi_pkg.
module gqi_datapath import gqi_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   input  logic [1:0]               opcode,
   input  logic signed [RATE_W-1:0] rate_sx,
   input  logic signed [RATE_W-1:0] rate_sy,
   input  logic signed [RATE_W-1:0] rate_sz,
   input  logic [STEP_W-1:0]        step_us,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]              csr_data,
   output logic signed [QUAT_W-1:0] att_out [4],
   output logic signed [RATE_W-1:0] rate_out [3]
);

   logic signed [RATE_W-1:0] bias_ff [3];
   logic signed [QUAT_W-1:0] launch_ff [4];
   logic signed [QUAT_W-1:0] q_ff [4];
   logic signed [RATE_W-1:0] rb_ff [3];
   logic [STEP_W-1:0]        dt_ff;
   logic signed [40:0]       a_ff [3];
   logic signed [65:0]       acc_ff;
   logic signed [65:0]       prod_ff;
   logic signed [QUAT_W-1:0] h_ff [3];
   logic signed [35:0]       d_ff [4];
   logic [65:0]              ssum_ff;
   logic [63:0]              srem_ff;
   logic [63:0]              sres_ff;
   logic [61:0]              x_ff;
   logic [33:0]              drem_ff;
   logic [32:0]              dquo_ff;
   logic                     dsat_ff;
   logic                     dneg_ff;
   logic signed [QUAT_W-1:0] att_ff [4];
   logic signed [RATE_W-1:0] rout_ff [3];

   logic signed [32:0] mul_a, mul_b;
   logic [4:0]         k, ka, tk;
   term_type           sel;
   logic signed [67:0] hsum, tsum;
   logic signed [35:0] term;
   logic signed [21:0] rb_in [3];
   logic [63:0]        sbit, strial;
   logic [31:0]        nrt;
   logic signed [32:0] qx, qm;
   logic [61:0]        x_in;
   logic [33:0]        r2;
   logic [5:0]         dj;
   logic               rbig;
   logic signed [QUAT_W-1:0] rpos;

   assign k    = cmd.step[5:1];
   assign ka   = k - 5'd3;
   assign tk   = k - 5'd9;
   assign sel  = term_sel(tk[3:0]);
   assign hsum = (68'(prod_ff) <<< 20) + 68'(acc_ff)
               + (68'sd1 <<< (HALF_RAD_SHIFT - 1));
   assign tsum = 68'(prod_ff) + (68'sd1 <<< (QUAT_FRAC_BITS - 1));
   assign term = 36'(tsum >>> QUAT_FRAC_BITS);
   assign sbit = 64'd1 << {6'd32 - cmd.step, 1'b0};
   assign strial = sres_ff + sbit;
   assign nrt  = sres_ff[31:0];
   assign qx   = 33'(q_ff[cmd.part]);
   assign qm   = qx[32] ? -qx : qx;
   assign x_in = {qm[31:0], 30'b0} + 62'(nrt[31:1]);
   assign dj   = 6'd33 - cmd.step;
   assign r2   = {drem_ff[32:0], x_ff[dj]};
   assign rbig = dsat_ff | dquo_ff[32] | dquo_ff[31];
   assign rpos = $signed({1'b0, dquo_ff[30:0]});

   assign rb_in[0] = 22'(rate_sz) - 22'(bias_ff[0]);
   assign rb_in[1] = 22'(rate_sy) - 22'(bias_ff[1]);
   assign rb_in[2] = -22'(rate_sx) - 22'(bias_ff[2]);

   assign status.zero_norm = (ssum_ff == '0);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.op == DP_MUL) begin
         if (k < 5'd3) begin
            mul_a = 33'(rb_ff[k[1:0]]);
            mul_b = 33'($signed({1'b0, dt_ff}));
         end else if (k < 5'd9) begin
            mul_a = ka[0] ? 33'(a_ff[ka[2:1]] >>> 20)
                          : 33'($signed({1'b0, a_ff[ka[2:1]][19:0]}));
            mul_b = 33'(HALF_RAD_K);
         end else begin
            mul_a = 33'(h_ff[sel.h]);
            mul_b = 33'(q_ff[sel.q]);
         end
      end else if (cmd.op == DP_SQ) begin
         mul_a = 33'(q_ff[cmd.step[2:1]]);
         mul_b = 33'(q_ff[cmd.step[2:1]]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff   <= '{default: '0};
         launch_ff <= '{Q_ONE, '0, '0, '0};
         q_ff      <= '{Q_ONE, '0, '0, '0};
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_BIAS_X:   bias_ff[0]   <= csr_data[RATE_W-1:0];
               CSR_BIAS_Y:   bias_ff[1]   <= csr_data[RATE_W-1:0];
               CSR_BIAS_Z:   bias_ff[2]   <= csr_data[RATE_W-1:0];
               CSR_LAUNCH_W: launch_ff[0] <= csr_data;
               CSR_LAUNCH_X: launch_ff[1] <= csr_data;
               CSR_LAUNCH_Y: launch_ff[2] <= csr_data;
               CSR_LAUNCH_Z: launch_ff[3] <= csr_data;
               default: ;
            endcase
         end
         unique case (cmd.op)
            DP_LOAD: begin
               if (opcode_type'(opcode) == OP_IDENTITY) q_ff <= '{Q_ONE, '0, '0, '0};
               if (opcode_type'(opcode) == OP_LAUNCH)   q_ff <= launch_ff;
            end
            DP_UPDATE: begin
               for (int i = 0; i < 4; i++) q_ff[i] <= sat_q(68'(q_ff[i]) + 68'(d_ff[i]));
            end
            DP_SQRT: begin
               if (cmd.step == '0 && status.zero_norm) q_ff <= '{Q_ONE, '0, '0, '0};
            end
            DP_DIV: begin
               if (cmd.step == DIV_LAST) begin
                  if (dneg_ff) q_ff[cmd.part] <= rbig ? Q_MIN : -rpos;
                  else         q_ff[cmd.part] <= rbig ? Q_MAX : rpos;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      unique case (cmd.op)
         DP_LOAD: begin
            dt_ff <= step_us;
            d_ff  <= '{default: '0};
            for (int i = 0; i < 3; i++)
               rb_ff[i] <= (opcode_type'(opcode) == OP_INTEGRATE) ? sat_rate(rb_in[i]) : '0;
         end
         DP_MUL: begin
            if (cmd.step[0]) begin
               if (k < 5'd3) begin
                  a_ff[k[1:0]] <= 41'(prod_ff);
               end else if (k < 5'd9) begin
                  if (ka[0]) h_ff[ka[2:1]] <= sat_q(hsum >>> HALF_RAD_SHIFT);
                  else       acc_ff <= prod_ff;
               end else begin
                  d_ff[sel.d] <= sel.neg ? d_ff[sel.d] - term : d_ff[sel.d] + term;
               end
            end
         end
         DP_UPDATE: ssum_ff <= '0;
         DP_SQ: begin
            if (cmd.step[0]) ssum_ff <= ssum_ff + 66'(unsigned'(prod_ff));
         end
         DP_SQRT: begin
            if (cmd.step == '0) begin
               srem_ff <= (ssum_ff[65:64] != 2'b00) ? '1 : ssum_ff[63:0];
               sres_ff <= '0;
            end else if (srem_ff >= strial) begin
               srem_ff <= srem_ff - strial;
               sres_ff <= (sres_ff >> 1) + sbit;
            end else begin
               sres_ff <= sres_ff >> 1;
            end
         end
         DP_DIV: begin
            if (cmd.step == '0) begin
               x_ff    <= x_in;
               drem_ff <= 34'(x_in[61:33]);
               dsat_ff <= 32'(x_in[61:33]) >= nrt;
               dneg_ff <= qx[32];
               dquo_ff <= '0;
            end else if (cmd.step != DIV_LAST) begin
               if (r2 >= {2'b00, nrt}) begin
                  drem_ff <= r2 - {2'b00, nrt};
                  dquo_ff <= {dquo_ff[31:0], 1'b1};
               end else begin
                  drem_ff <= r2;
                  dquo_ff <= {dquo_ff[31:0], 1'b0};
               end
            end
         end
         DP_PUBLISH: begin
            att_ff  <= q_ff;
            rout_ff <= rb_ff;
         end
         default: ;
      endcase
   end

   assign att_out  = att_ff;
   assign rate_out = rout_ff;

endmodule

// ===== design/gqi_ctrl.sv =====
// Controller: sequences the datapath phases and runs both handshakes.
// Drives gqi_datapath through dp_cmd_type; depends on gqi_pkg.
module gqi_ctrl import gqi_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    opcode,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_MUL  = 7'b0000010,
      S_UPD  = 7'b0000100,
      S_SQ   = 7'b0001000,
      S_SQRT = 7'b0010000,
      S_DIV  = 7'b0100000,
      S_PUB  = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] step_ff, step_in;
   logic [1:0] part_ff, part_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept, publish;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign publish   = (state_ff == S_PUB) & (~rsp_valid_ff | rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff + 6'd1;
      part_in      = part_ff;
      rsp_valid_in = publish | (rsp_valid_ff & ~rsp_ready);
      cmd          = '{op: DP_IDLE, step: step_ff, part: part_ff};
      unique case (state_ff)
         S_IDLE: begin
            step_in = '0;
            part_in = '0;
            if (accept) begin
               cmd.op   = DP_LOAD;
               state_in = (opcode_type'(opcode) == OP_INTEGRATE) ? S_MUL : S_PUB;
            end
         end
         S_MUL: begin
            cmd.op = DP_MUL;
            if (step_ff == MUL_LAST) state_in = S_UPD;
         end
         S_UPD: begin
            cmd.op   = DP_UPDATE;
            step_in  = '0;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.op = DP_SQ;
            if (step_ff == SQ_LAST) begin
               step_in  = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.op = DP_SQRT;
            if (step_ff == '0 && status.zero_norm) begin
               state_in = S_PUB;
            end else if (step_ff == SQRT_LAST) begin
               step_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.op = DP_DIV;
            if (step_ff == DIV_LAST) begin
               step_in = '0;
               part_in = part_ff + 2'd1;
               if (part_ff == 2'd3) state_in = S_PUB;
            end
         end
         S_PUB: begin
            if (publish) begin
               cmd.op   = DP_PUBLISH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         part_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         part_ff      <= part_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_pub_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_PUBLISH) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result published over an untaken result");
   a_int_path: assert property (@(posedge clock) disable iff (reset)
      (accept && opcode == OP_INTEGRATE) |=> (state_ff == S_MUL))
      else $error("integrate item did not start the multiply phase");
   a_load_path: assert property (@(posedge clock) disable iff (reset)
      (accept && opcode != OP_INTEGRATE) |=> (state_ff == S_PUB))
      else $error("reset item did not go straight to publish");
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && step_ff == DIV_LAST && part_ff == 2'd3) |=> (state_ff == S_PUB))
      else $error("divide phase did not end after the last part");

endmodule

// ===== design/gyro_quaternion_integrator.sv =====
// Gyro quaternion integrator top level: joins gqi_ctrl and gqi_datapath.
// Integrate item: load, multiply, update, square, root, divide of each of the four
// parts, publish; reset items go from load to publish; zero norm skips to publish.
// One item at a time; the next is taken once the previous is published, while
// the published result may still wait. Synchronous active-high reset restores
// the identity attitude, zero offsets and the identity launch-rod quaternion.
module gyro_quaternion_integrator import gqi_pkg::*; (
   input logic   clock,
   input logic   reset,
   gqi_req_if.sink   req_ch,
   gqi_rsp_if.source rsp_ch,
   gqi_csr_if.sink   csr_ch
);

   dp_cmd_type               cmd;
   dp_status_type            status;
   logic signed [QUAT_W-1:0] att_out [4];
   logic signed [RATE_W-1:0] rate_out [3];

   assign csr_ch.ready = 1'b1;

   gqi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .opcode    (req_ch.opcode),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   gqi_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .opcode    (req_ch.opcode),
      .rate_sx   (req_ch.rate_sx),
      .rate_sy   (req_ch.rate_sy),
      .rate_sz   (req_ch.rate_sz),
      .step_us   (req_ch.step_us),
      .csr_we    (csr_ch.valid),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .att_out   (att_out),
      .rate_out  (rate_out)
   );

   assign rsp_ch.att_w       = att_out[0];
   assign rsp_ch.att_x       = att_out[1];
   assign rsp_ch.att_y       = att_out[2];
   assign rsp_ch.att_z       = att_out[3];
   assign rsp_ch.body_rate_x = rate_out[0];
   assign rsp_ch.body_rate_y = rate_out[1];
   assign rsp_ch.body_rate_z = rate_out[2];

endmodule
